// ----- design/dttsm_pkg.sv -----
`default_nettype none

package dttsm_pkg;

    localparam int MAX_TRACKS = 128;
    localparam int IDX_W      = $clog2(MAX_TRACKS);
    localparam int CNT_W      = $clog2(MAX_TRACKS + 1);

    localparam int ADDR_W  = 24;
    localparam int OFF_W   = 32;
    localparam int SIZE_W  = 12;
    localparam int CTRL_W  = 4;

    // Lead-out plus lead-in between two sessions, in frames.
    localparam logic [ADDR_W-1:0] SESSION_GAP = ADDR_W'(11400 - 150);

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CLOSE  = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_MISS = 2'd2;

    localparam logic [1:0] MODE_AUDIO = 2'd0;
    localparam logic [1:0] MODE_1     = 2'd1;
    localparam logic [1:0] MODE_2     = 2'd2;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_XA    = 2'd1;
    localparam logic [1:0] KIND_MIXED = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] pregap_sectors;
        logic [ADDR_W-1:0] track_sectors;
        logic [SIZE_W-1:0] block_size;
        logic [1:0]        track_mode;
        logic [CTRL_W-1:0] control_bits;
        logic [ADDR_W-1:0] sector_address;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [6:0]        track_index;
        logic [ADDR_W-1:0] start_address;
        logic [OFF_W-1:0]  byte_offset;
        logic [SIZE_W-1:0] sector_bytes;
        logic [CTRL_W-1:0] track_control;
        logic              session_first;
        logic [1:0]        disc_kind;
    } rsp_t;

    // Bit 0 audio seen, bit 1 mode 1 seen, bit 2 mode 2 seen.
    function automatic logic [1:0] disc_kind_of(input logic [2:0] modes);
        logic [1:0] kind;
        kind = KIND_DATA;
        if (modes[1] && !modes[0] && !modes[2])
            kind = KIND_DATA;
        else if (modes[2])
            kind = KIND_XA;
        else if (modes[0] && modes[1])
            kind = KIND_MIXED;
        return kind;
    endfunction

endpackage

`default_nettype wire

// ----- design/disc_track_table_sector_mapper_top.sv -----
`default_nettype none
// Disc track table and sector mapper.
//
// The request channel (req_valid, req_ready, req) carries one command per beat:
// add a track, close a session, look up a frame, or clear the table. Every
// request beat yields exactly one response beat on rsp_valid, rsp_ready, rsp.
//
// Requests are handled one at a time by a small sequencer around one shared
// 24x12 multiplier and the four track memories (one registered read port each).
// req_ready is high only while the sequencer is idle. Close, clear, a table-full
// add and a lookup on an empty table go straight to the final step; an add first
// passes the pregap multiply, the table write and the length step. A lookup with
// two or more loaded tracks walks linearly over the start memory at one entry per
// cycle, then reads, checks and scales the chosen entry before the final step.
// The response sits in an output register. If the receiver stalls, the next
// request is still taken and worked; it waits in its final step until the
// output register has been emptied, so no beat is lost or reordered.
// Reset clears the control state, the running address and offset, the mode
// history and the track count. The track memories are not cleared; entries
// at or above the track count are never used.

module disc_track_table_sector_mapper_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire dttsm_pkg::req_t req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output dttsm_pkg::rsp_t      rsp
);

    import dttsm_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_ADD_MUL = 11'b000_0000_0010,
        ST_ADD_WR  = 11'b000_0000_0100,
        ST_ADD_LEN = 11'b000_0000_1000,
        ST_LK_WAIT = 11'b000_0001_0000,
        ST_LK_SCAN = 11'b000_0010_0000,
        ST_LK_RD   = 11'b000_0100_0000,
        ST_LK_CHK  = 11'b000_1000_0000,
        ST_LK_MUL  = 11'b001_0000_0000,
        ST_LK_FIN  = 11'b010_0000_0000,
        ST_FIN     = 11'b100_0000_0000
    } state_t;

    // Track memories.
    logic [ADDR_W-1:0] start_mem   [MAX_TRACKS];
    logic [OFF_W-1:0]  offset_mem  [MAX_TRACKS];
    logic [SIZE_W-1:0] size_mem    [MAX_TRACKS];
    logic [CTRL_W-1:0] control_mem [MAX_TRACKS];

    // Control state.
    state_t            state_reg,     state_next;
    logic [CNT_W-1:0]  tracks_reg,    tracks_next;
    logic [ADDR_W-1:0] run_addr_reg,  run_addr_next;
    logic [OFF_W-1:0]  run_off_reg,   run_off_next;
    logic [2:0]        modes_reg,     modes_next;
    logic              sess_open_reg, sess_open_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // Datapath registers.
    req_t              req_reg,       req_next;
    rsp_t              res_reg,       res_next;
    rsp_t              rsp_reg,       rsp_next;
    logic [ADDR_W-1:0] mul_a_reg,     mul_a_next;
    logic [SIZE_W-1:0] mul_b_reg,     mul_b_next;
    logic [OFF_W-1:0]  prod_reg;
    logic [IDX_W-1:0]  rd_addr_reg,   rd_addr_next;
    logic [IDX_W-1:0]  chk_reg,       chk_next;
    logic [ADDR_W-1:0] start_q;
    logic [OFF_W-1:0]  offset_q;
    logic [SIZE_W-1:0] size_q;
    logic [CTRL_W-1:0] control_q;

    logic [ADDR_W+SIZE_W-1:0] prod_full;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_start;
    logic [OFF_W-1:0]  wr_offset;
    logic              req_fire;
    logic              rsp_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The one multiplier; its product is always registered before use.
    assign prod_full = (ADDR_W + SIZE_W)'(mul_a_reg) * (ADDR_W + SIZE_W)'(mul_b_reg);

    // Track start and offset of the entry being written, past its pregap.
    assign wr_start  = run_addr_reg + req_reg.pregap_sectors;
    assign wr_offset = run_off_reg + prod_reg;

    always_comb
    begin
        state_next     = state_reg;
        tracks_next    = tracks_reg;
        run_addr_next  = run_addr_reg;
        run_off_next   = run_off_reg;
        modes_next     = modes_reg;
        sess_open_next = sess_open_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_next       = req_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        rd_addr_next   = rd_addr_reg;
        chk_next       = chk_reg;
        wr_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    req_next   = req;
                    res_next   = '0;
                    mul_a_next = req.pregap_sectors;
                    mul_b_next = req.block_size;
                    unique case (req.command)
                        CMD_ADD:
                        begin
                            if (tracks_reg >= CNT_W'(MAX_TRACKS))
                            begin
                                res_next.status = STAT_FULL;
                                state_next      = ST_FIN;
                            end
                            else
                            begin
                                state_next = ST_ADD_MUL;
                            end
                        end
                        CMD_CLOSE:
                        begin
                            run_addr_next          = run_addr_reg + SESSION_GAP;
                            sess_open_next         = 1'b0;
                            res_next.start_address = run_addr_reg + SESSION_GAP;
                            res_next.byte_offset   = run_off_reg;
                            state_next             = ST_FIN;
                        end
                        CMD_LOOKUP:
                        begin
                            if (tracks_reg == '0)
                            begin
                                res_next.status = STAT_MISS;
                                state_next      = ST_FIN;
                            end
                            else if (tracks_reg == CNT_W'(1))
                            begin
                                // A single track always qualifies.
                                rd_addr_next = '0;
                                state_next   = ST_LK_RD;
                            end
                            else
                            begin
                                rd_addr_next = IDX_W'(1);
                                state_next   = ST_LK_WAIT;
                            end
                        end
                        default:
                        begin
                            tracks_next    = '0;
                            run_addr_next  = '0;
                            run_off_next   = '0;
                            modes_next     = '0;
                            sess_open_next = 1'b0;
                            state_next     = ST_FIN;
                        end
                    endcase
                end
            end

            ST_ADD_MUL:
            begin
                // Pregap product lands this edge; queue the length product.
                mul_a_next = req_reg.track_sectors;
                state_next = ST_ADD_WR;
            end

            ST_ADD_WR:
            begin
                wr_en          = 1'b1;
                run_addr_next  = wr_start;
                run_off_next   = wr_offset;
                sess_open_next = 1'b1;
                unique case (req_reg.track_mode)
                    MODE_AUDIO: modes_next = modes_reg | 3'b001;
                    MODE_1:     modes_next = modes_reg | 3'b010;
                    MODE_2:     modes_next = modes_reg | 3'b100;
                    default:    modes_next = modes_reg;
                endcase
                res_next.track_index   = 7'(tracks_reg[IDX_W-1:0]);
                res_next.start_address = wr_start;
                res_next.byte_offset   = wr_offset;
                res_next.sector_bytes  = req_reg.block_size;
                res_next.track_control = req_reg.control_bits;
                res_next.session_first = !sess_open_reg;
                state_next             = ST_ADD_LEN;
            end

            ST_ADD_LEN:
            begin
                run_off_next  = run_off_reg + prod_reg;
                run_addr_next = run_addr_reg + req_reg.track_sectors;
                tracks_next   = tracks_reg + CNT_W'(1);
                state_next    = ST_FIN;
            end

            ST_LK_WAIT:
            begin
                chk_next     = rd_addr_reg;
                rd_addr_next = rd_addr_reg + IDX_W'(1);
                state_next   = ST_LK_SCAN;
            end

            ST_LK_SCAN:
            begin
                // start_q holds the start of entry chk_reg, the successor of
                // the candidate chk_reg - 1.
                if (start_q > req_reg.sector_address)
                begin
                    rd_addr_next = chk_reg - IDX_W'(1);
                    state_next   = ST_LK_RD;
                end
                else if ((CNT_W'(chk_reg) + CNT_W'(1)) >= tracks_reg)
                begin
                    rd_addr_next = chk_reg;
                    state_next   = ST_LK_RD;
                end
                else
                begin
                    chk_next     = chk_reg + IDX_W'(1);
                    rd_addr_next = rd_addr_reg + IDX_W'(1);
                end
            end

            ST_LK_RD:
            begin
                state_next = ST_LK_CHK;
            end

            ST_LK_CHK:
            begin
                if (req_reg.sector_address < start_q)
                begin
                    res_next.status = STAT_MISS;
                    state_next      = ST_FIN;
                end
                else
                begin
                    mul_a_next = req_reg.sector_address - start_q;
                    mul_b_next = size_q;
                    state_next = ST_LK_MUL;
                end
            end

            ST_LK_MUL:
            begin
                state_next = ST_LK_FIN;
            end

            ST_LK_FIN:
            begin
                res_next.track_index   = 7'(rd_addr_reg);
                res_next.start_address = start_q;
                res_next.byte_offset   = offset_q + prod_reg;
                res_next.sector_bytes  = size_q;
                res_next.track_control = control_q;
                state_next             = ST_FIN;
            end

            ST_FIN:
            begin
                // Wait here while the output register still holds a beat.
                if (rsp_free)
                begin
                    rsp_next           = res_reg;
                    rsp_next.disc_kind = disc_kind_of(modes_reg);
                    rsp_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tracks_reg    <= '0;
            run_addr_reg  <= '0;
            run_off_reg   <= '0;
            modes_reg     <= '0;
            sess_open_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tracks_reg    <= tracks_next;
            run_addr_reg  <= run_addr_next;
            run_off_reg   <= run_off_next;
            modes_reg     <= modes_next;
            sess_open_reg <= sess_open_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        prod_reg    <= prod_full[OFF_W-1:0];
        rd_addr_reg <= rd_addr_next;
        chk_reg     <= chk_next;
    end

    // Track memories: one write port at the track count, one registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[tracks_reg[IDX_W-1:0]]   <= wr_start;
            offset_mem[tracks_reg[IDX_W-1:0]]  <= wr_offset;
            size_mem[tracks_reg[IDX_W-1:0]]    <= req_reg.block_size;
            control_mem[tracks_reg[IDX_W-1:0]] <= req_reg.control_bits;
        end
        start_q   <= start_mem[rd_addr_reg];
        offset_q  <= offset_mem[rd_addr_reg];
        size_q    <= size_mem[rd_addr_reg];
        control_q <= control_mem[rd_addr_reg];
    end

endmodule

`default_nettype wire

// ----- tb/disc_track_table_sector_mapper_checker.sv -----
`timescale 1ns / 100ps

module disc_track_table_sector_mapper_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    input  wire logic            req_ready,
    input  wire dttsm_pkg::req_t req,
    input  wire logic            rsp_valid,
    input  wire logic            rsp_ready,
    input  wire dttsm_pkg::rsp_t rsp,
    output int                   fail_count,
    output int                   pending
);

    import dttsm_pkg::*;

    localparam logic [1:0] MODE_UNKNOWN = 2'd3;

    // Shadow copy of the track table and the running counters.
    logic [ADDR_W-1:0] trk_start  [MAX_TRACKS];
    logic [OFF_W-1:0]  trk_offset [MAX_TRACKS];
    logic [SIZE_W-1:0] trk_size   [MAX_TRACKS];
    logic [CTRL_W-1:0] trk_ctrl   [MAX_TRACKS];
    int unsigned       trk_count;
    logic [ADDR_W-1:0] run_addr;
    logic [OFF_W-1:0]  run_offset;
    logic [2:0]        modes_seen;
    logic              session_open;

    rsp_t expected_q [$];
    rsp_t want;
    int   rsp_beats;

    function automatic void clear_map();
        trk_count    = 0;
        run_addr     = '0;
        run_offset   = '0;
        modes_seen   = '0;
        session_open = 1'b0;
    endfunction

    // Bit 0 is audio, bit 1 mode 1, bit 2 mode 2.
    function automatic logic [1:0] kind_from_modes(input logic [2:0] seen);
        logic [1:0] kind;
        kind = KIND_DATA;
        if (seen[2])
            kind = KIND_XA;
        else if (seen[0] && seen[1])
            kind = KIND_MIXED;
        return kind;
    endfunction

    // Applies one request to the shadow table and returns the response it must produce.
    function automatic rsp_t map_request(input req_t r);
        rsp_t             res;
        int unsigned      slot;
        int unsigned      hit;
        int unsigned      i;
        bit               found;
        logic [OFF_W-1:0] delta;
        res   = '0;
        found = 1'b0;
        hit   = 0;
        case (r.command)
            CMD_ADD:
            begin
                if (trk_count >= MAX_TRACKS)
                begin
                    res.status = STAT_FULL;
                end
                else
                begin
                    slot       = trk_count;
                    run_addr   = run_addr + r.pregap_sectors;
                    run_offset = run_offset + OFF_W'(r.pregap_sectors) * OFF_W'(r.block_size);
                    res.session_first = !session_open;
                    session_open      = 1'b1;
                    if (r.track_mode != MODE_UNKNOWN)
                        modes_seen[r.track_mode] = 1'b1;
                    trk_start[slot]   = run_addr;
                    trk_offset[slot]  = run_offset;
                    trk_size[slot]    = r.block_size;
                    trk_ctrl[slot]    = r.control_bits;
                    res.status        = STAT_OK;
                    res.track_index   = 7'(slot);
                    res.start_address = run_addr;
                    res.byte_offset   = run_offset;
                    res.sector_bytes  = r.block_size;
                    res.track_control = r.control_bits;
                    run_offset = run_offset + OFF_W'(r.track_sectors) * OFF_W'(r.block_size);
                    run_addr   = run_addr + r.track_sectors;
                    trk_count  = slot + 1;
                end
            end
            CMD_CLOSE:
            begin
                run_addr          = run_addr + SESSION_GAP;
                session_open      = 1'b0;
                res.start_address = run_addr;
                res.byte_offset   = run_offset;
            end
            CMD_LOOKUP:
            begin
                // The first track whose successor starts past the frame wins.
                for (i = 0; i < trk_count && !found; i++)
                begin
                    if (i + 1 >= trk_count || trk_start[i + 1] > r.sector_address)
                    begin
                        found = 1'b1;
                        hit   = i;
                    end
                end
                if (!found || r.sector_address < trk_start[hit])
                begin
                    res.status = STAT_MISS;
                end
                else
                begin
                    delta             = OFF_W'(r.sector_address - trk_start[hit]);
                    res.status        = STAT_OK;
                    res.track_index   = 7'(hit);
                    res.start_address = trk_start[hit];
                    res.sector_bytes  = trk_size[hit];
                    res.track_control = trk_ctrl[hit];
                    res.byte_offset   = trk_offset[hit] + delta * OFF_W'(trk_size[hit]);
                end
            end
            CMD_CLEAR:
            begin
                clear_map();
            end
        endcase
        res.disc_kind = kind_from_modes(modes_seen);
        return res;
    endfunction

    task automatic log_failure(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            log_failure($sformatf("beat %0d %s got %0h expected %0h",
                                  rsp_beats, name, got, exp_val));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_map();
            expected_q.delete();
            pending    = 0;
            fail_count = 0;
            rsp_beats  = 0;
        end
        else
        begin
            // Responses are retired first; a response can never belong to a
            // request taken at the same edge.
            if (rsp_valid && rsp_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    log_failure($sformatf("beat %0d arrived with nothing expected", rsp_beats));
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("status", 32'(rsp.status), 32'(want.status));
                    check_field("track_index", 32'(rsp.track_index), 32'(want.track_index));
                    check_field("start_address", 32'(rsp.start_address),
                                32'(want.start_address));
                    check_field("byte_offset", rsp.byte_offset, want.byte_offset);
                    check_field("sector_bytes", 32'(rsp.sector_bytes), 32'(want.sector_bytes));
                    check_field("track_control", 32'(rsp.track_control),
                                32'(want.track_control));
                    check_field("session_first", 32'(rsp.session_first),
                                32'(want.session_first));
                    check_field("disc_kind", 32'(rsp.disc_kind), 32'(want.disc_kind));
                end
                rsp_beats++;
            end
            if (req_valid && req_ready)
                expected_q.push_back(map_request(req));
            pending = expected_q.size();
        end
    end

endmodule

// ----- tb/tb_disc_track_table_sector_mapper_top.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the disc track table mapper. The checker beside the
// block watches both channels, predicts every response beat and counts
// mismatches; this module only generates traffic and decides the outcome.
module tb_disc_track_table_sector_mapper_top;

    import dttsm_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int MAX_GAP      = 17;
    // The receiver stops taking beats for a long stretch once, at this beat.
    localparam int HOLD_AT_BEAT = 240;
    localparam int HOLD_CYCLES  = 400;
    // Cycles without any accepted beat before the run is declared hung.
    localparam int IDLE_LIMIT   = 4000;
    // Quiet time after the last expected beat, to catch stray responses.
    localparam int DRAIN_CYCLES = 200;
    localparam int FILL_LIMIT   = 3;

    localparam logic [1:0]        MODE_UNKNOWN = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_MAX     = '1;
    localparam logic [SIZE_W-1:0] SIZE_MAX     = 12'd2448;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    req_t req       = '0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp;
    int   fail_count;
    int   pending;

    // Rough layout of the disc as sent so far. It only steers lookups toward
    // interesting frames; the checker holds the real prediction.
    logic [ADDR_W-1:0] plan_addr;
    logic [ADDR_W-1:0] plan_start [$];
    int                plan_count;
    int                items_sent;
    int                fills_done;
    int                idle_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    disc_track_table_sector_mapper_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    disc_track_table_sector_mapper_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic req_t beat_of(input logic [1:0]        cmd,
                                     input logic [ADDR_W-1:0] pregap,
                                     input logic [ADDR_W-1:0] len,
                                     input logic [SIZE_W-1:0] bsize,
                                     input logic [1:0]        mode,
                                     input logic [CTRL_W-1:0] ctrl,
                                     input logic [ADDR_W-1:0] frame);
        req_t b;
        b.command        = cmd;
        b.pregap_sectors = pregap;
        b.track_sectors  = len;
        b.block_size     = bsize;
        b.track_mode     = mode;
        b.control_bits   = ctrl;
        b.sector_address = frame;
        return b;
    endfunction

    // Offers one request beat and returns at the falling edge after it was
    // taken. With no gap drawn, valid simply stays high for the next beat.
    // Every fourth block of a hundred beats is sent without any gap.
    task automatic issue(input req_t item);
        int gap;
        gap = ((items_sent / 100) % 4 == 1) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
        items_sent++;
        case (item.command)
            CMD_ADD:
            begin
                if (plan_count < MAX_TRACKS)
                begin
                    plan_addr = plan_addr + item.pregap_sectors;
                    plan_start.push_back(plan_addr);
                    plan_addr = plan_addr + item.track_sectors;
                    plan_count++;
                end
            end
            CMD_CLOSE:
                plan_addr = plan_addr + SESSION_GAP;
            CMD_LOOKUP:
                ;
            CMD_CLEAR:
            begin
                plan_addr  = '0;
                plan_count = 0;
                plan_start.delete();
            end
        endcase
    endtask

    // Close and clear carry random content in the fields they ignore.
    task automatic issue_plain(input logic [1:0] cmd);
        issue(beat_of(cmd, ADDR_W'($urandom), ADDR_W'($urandom),
                      SIZE_W'($urandom_range(0, SIZE_MAX)), 2'($urandom),
                      CTRL_W'($urandom), ADDR_W'($urandom)));
    endtask

    // A track as a real image would describe it, with an occasional oddity:
    // huge pregaps or lengths that wrap the address, empty tracks, the
    // unknown mode, and block sizes off the usual list.
    task automatic add_random_track();
        logic [ADDR_W-1:0] pregap;
        logic [ADDR_W-1:0] len;
        logic [SIZE_W-1:0] bsize;
        logic [1:0]        mode;
        int                pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            pregap = '0;
        else if (pick < 6)
            pregap = 24'd150;
        else if (pick < 9)
            pregap = ADDR_W'($urandom_range(0, 300));
        else
            pregap = ADDR_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            len = '0;
        else if (pick == 9)
            len = ADDR_W'($urandom);
        else
            len = ADDR_W'($urandom_range(1, 20000));
        case ($urandom_range(0, 6))
            0:       bsize = 12'd2048;
            1:       bsize = 12'd2336;
            2:       bsize = 12'd2352;
            3:       bsize = SIZE_MAX;
            4:       bsize = '0;
            default: bsize = SIZE_W'($urandom_range(0, SIZE_MAX));
        endcase
        if ($urandom_range(0, 9) == 0)
            mode = MODE_UNKNOWN;
        else
            mode = 2'($urandom_range(MODE_AUDIO, MODE_2));
        issue(beat_of(CMD_ADD, pregap, len, bsize, mode, CTRL_W'($urandom),
                      ADDR_W'($urandom)));
    endtask

    // Half of the lookups land on or next to a track boundary or the end of the
    // last track, where the search and the miss case are decided.
    task automatic lookup_random();
        logic [ADDR_W-1:0] frame;
        logic [ADDR_W-1:0] base;
        int                pick;
        pick = $urandom_range(0, 9);
        if (plan_start.size() == 0 || pick == 0)
        begin
            frame = ADDR_W'($urandom);
        end
        else
        begin
            base = plan_start[$urandom_range(0, plan_start.size() - 1)];
            case (pick)
                1:       frame = base - 1'b1;
                2:       frame = base;
                3:       frame = base + 1'b1;
                4:       frame = plan_addr - 1'b1;
                5:       frame = plan_addr;
                default: frame = base + ADDR_W'($urandom_range(0, 20000));
            endcase
        end
        issue(beat_of(CMD_LOOKUP, ADDR_W'($urandom), ADDR_W'($urandom),
                      SIZE_W'($urandom_range(0, SIZE_MAX)), 2'($urandom),
                      CTRL_W'($urandom), frame));
    endtask

    // Receiver. It draws a stall before every beat, takes every third block
    // of 128 beats without stalling, and once holds off long enough that the
    // block backs up and drops req_ready while the sender keeps offering.
    initial
    begin : receiver
        int hold;
        int beats;
        beats = 0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (beats == HOLD_AT_BEAT)
                hold = HOLD_CYCLES;
            else if ((beats / 128) % 3 == 2)
                hold = 0;
            else
                hold = $urandom_range(0, MAX_GAP);
            if (hold > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            beats++;
            @(negedge clk);
        end
    end

    // Hang detection: any accepted beat on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            idle_cycles <= 0;
        end
        else if (rst_n)
        begin
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        int last_item;
        int fill_due;
        int tracks;
        int choice;
        plan_addr  = '0;
        plan_count = 0;
        items_sent = 0;
        fills_done = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. An empty table must miss at both ends of the frame
        // range, and closing or clearing an empty table is harmless.
        issue(beat_of(CMD_LOOKUP, '0, '0, '0, MODE_AUDIO, '0, '0));
        issue(beat_of(CMD_LOOKUP, '0, '0, '0, MODE_AUDIO, '0, ADDR_MAX));
        issue(beat_of(CMD_CLOSE, '0, '0, '0, MODE_AUDIO, '0, '0));
        issue(beat_of(CMD_CLEAR, '0, '0, '0, MODE_AUDIO, '0, '0));
        // An audio track after the usual two-second pregap, then a frame just
        // before it, its first frame and its last frame.
        issue(beat_of(CMD_ADD, 24'd150, 24'd1000, 12'd2352, MODE_AUDIO, 4'd0, '0));
        issue(beat_of(CMD_LOOKUP, '0, '0, '0, MODE_AUDIO, '0, 24'd149));
        issue(beat_of(CMD_LOOKUP, '0, '0, '0, MODE_AUDIO, '0, 24'd150));
        issue(beat_of(CMD_LOOKUP, '0, '0, '0, MODE_AUDIO, '0, 24'd1149));
        // A mode 1 track right behind it makes the disc mixed.
        issue(beat_of(CMD_ADD, '0, 24'd500, 12'd2048, MODE_1, 4'd4, '0));
        issue(beat_of(CMD_LOOKUP, '0, '0, '0, MODE_AUDIO, '0, 24'd1150));
        issue(beat_of(CMD_LOOKUP, '0, '0, '0, MODE_AUDIO, '0, ADDR_MAX));
        // A new session: its first track is flagged and mode 2 makes it XA.
        issue(beat_of(CMD_CLOSE, '0, '0, '0, MODE_AUDIO, '0, '0));
        issue(beat_of(CMD_ADD, 24'd150, 24'd300, 12'd2336, MODE_2, 4'd4, '0));
        // Largest fields everywhere, so address and offset both wrap, with
        // the unknown mode that must not mark anything as seen.
        issue(beat_of(CMD_ADD, ADDR_MAX, ADDR_MAX, SIZE_MAX, MODE_UNKNOWN, 4'hF, ADDR_MAX));
        issue(beat_of(CMD_LOOKUP, '0, '0, '0, MODE_AUDIO, '0, '0));
        issue(beat_of(CMD_LOOKUP, '0, '0, '0, MODE_AUDIO, '0, 24'd20000));
        issue(beat_of(CMD_CLEAR, '1, '1, SIZE_MAX, MODE_UNKNOWN, '1, '1));
        // Empty tracks of zero size stacked on frame zero; the later one wins.
        issue(beat_of(CMD_ADD, '0, '0, '0, MODE_1, '0, '0));
        issue(beat_of(CMD_LOOKUP, '0, '0, '0, MODE_AUDIO, '0, '0));
        issue(beat_of(CMD_ADD, '0, '0, '0, MODE_1, '0, '0));
        issue(beat_of(CMD_LOOKUP, '0, '0, '0, MODE_AUDIO, '0, '0));
        issue(beat_of(CMD_ADD, '0, 24'd10, 12'd2048, MODE_UNKNOWN, 4'd2, '0));
        issue(beat_of(CMD_LOOKUP, '0, '0, '0, MODE_AUDIO, '0, 24'd5));
        issue(beat_of(CMD_CLEAR, '0, '0, '0, MODE_AUDIO, '0, '0));

        // Random part: mostly short sessions of tracks with lookups between
        // them, a little pure noise, and a few passes that fill the table and
        // keep adding past the end.
        last_item = items_sent + RANDOM_ITEMS;
        fill_due  = items_sent + 400;
        while (items_sent < last_item)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 8)
            begin
                issue(beat_of(2'($urandom_range(0, 3)), ADDR_W'($urandom), ADDR_W'($urandom),
                              SIZE_W'($urandom_range(0, SIZE_MAX)), 2'($urandom),
                              CTRL_W'($urandom), ADDR_W'($urandom)));
            end
            else if ((choice < 10 && fills_done < FILL_LIMIT) ||
                     (fills_done == 0 && items_sent >= fill_due))
            begin
                fills_done++;
                issue_plain(CMD_CLEAR);
                while (plan_count < MAX_TRACKS)
                    add_random_track();
                repeat ($urandom_range(1, 3)) add_random_track();
                repeat (8) lookup_random();
                issue_plain(CMD_CLOSE);
                add_random_track();
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    issue_plain(CMD_CLEAR);
                tracks = $urandom_range(1, 6);
                repeat (tracks)
                begin
                    if ($urandom_range(0, 3) == 0)
                        issue_plain(CMD_CLOSE);
                    add_random_track();
                    repeat ($urandom_range(0, 3)) lookup_random();
                end
            end
        end
        req_valid <= 1'b0;

        // Wait for every predicted beat, then stay a while to catch extras.
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
